>>> rtl/blpg_pkg.sv
package blpg_pkg;

  // Width of the window size registers.
  localparam int unsigned WIN_BITS = 13;

  // Register file layout on the configuration port.
  localparam int unsigned APB_ADDR_BITS = 3;
  localparam int unsigned APB_DATA_BITS = 32;

  typedef logic [0:0] reg_idx_t;
  localparam reg_idx_t REG_WINDOW_WIDTH  = 1'b0;
  localparam reg_idx_t REG_WINDOW_HEIGHT = 1'b1;

  localparam logic [WIN_BITS-1:0] WINDOW_WIDTH_RST  = 13'd800;
  localparam logic [WIN_BITS-1:0] WINDOW_HEIGHT_RST = 13'd600;

  // Input beat kinds.
  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_STEP = 1'b1;

  // Line generator phases.
  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_LOOP  = 2'd1,
    PH_START = 2'd2,
    PH_END   = 2'd3
  } phase_e;

endpackage

>>> rtl/bresenham_line_pixel_generator.sv
// Line pixel generator.
// Input channel (in_valid_i / in_ready_o): a load beat (kind_i = 0) latches two
// end points and a colour and starts a new line, restarting any line in progress;
// it gives no output. A step beat (kind_i = 1) yields one pixel: first one pixel
// per unit of the major-axis delta along the line, then the start point, then the
// end point, which carries last_o. A step beat with no line active gives nothing.
// Output channel (out_valid_o / out_ready_i): one pixel per beat with its colour
// and an on-screen flag from clipping against the window registers.
// Configuration: an APB-style port with window_width at 0x0 and window_height at
// 0x4; write it only while the block is idle.
// Flow: an accepted beat is registered in the input register, processed by the
// line-state logic, and its pixel is loaded into the output register that drives
// out_valid_o. Throughput is one beat per cycle while the output is not stalled, set
// by the single registered pass of adds and compares that updates the line state.
// A finished pixel waits in the output register while the input register takes
// the next beat; when the receiver stalls and a step beat is waiting behind it,
// in_ready_o drops until the pixel is taken.
// Reset empties both registers, clears the line state (idle) and sets the window
// to 800 by 600.
module bresenham_line_pixel_generator
  import blpg_pkg::*;
#(
  parameter int unsigned COORD_BITS = 13
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // Input channel.
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                         kind_i,
  input  logic signed [COORD_BITS-1:0] start_x_i,
  input  logic signed [COORD_BITS-1:0] start_y_i,
  input  logic signed [COORD_BITS-1:0] end_x_i,
  input  logic signed [COORD_BITS-1:0] end_y_i,
  input  logic [7:0]                   red_in_i,
  input  logic [7:0]                   green_in_i,
  input  logic [7:0]                   blue_in_i,
  // Output channel.
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic signed [COORD_BITS-1:0] pixel_x_o,
  output logic signed [COORD_BITS-1:0] pixel_y_o,
  output logic [7:0]                   red_out_o,
  output logic [7:0]                   green_out_o,
  output logic [7:0]                   blue_out_o,
  output logic                         on_screen_o,
  output logic                         last_o,
  // Configuration port.
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [APB_ADDR_BITS-1:0]     paddr,
  input  logic [APB_DATA_BITS-1:0]     pwdata,
  output logic [APB_DATA_BITS-1:0]     prdata,
  output logic                         pready
);

  localparam int unsigned DIFF_BITS = COORD_BITS + 1;
  localparam int unsigned ERR_BITS  = COORD_BITS + 2;
  localparam int unsigned CMP_BITS  = (COORD_BITS > WIN_BITS) ? COORD_BITS : WIN_BITS;
  localparam logic [COORD_BITS-1:0] CB_ONE = COORD_BITS'(1);

  // Configuration registers.
  logic [WIN_BITS-1:0] win_w_q, win_h_q;
  reg_idx_t            reg_idx;
  logic                cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = paddr[APB_ADDR_BITS-1:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_w_q <= WINDOW_WIDTH_RST;
      win_h_q <= WINDOW_HEIGHT_RST;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_WINDOW_WIDTH:  win_w_q <= pwdata[WIN_BITS-1:0];
        REG_WINDOW_HEIGHT: win_h_q <= pwdata[WIN_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_WINDOW_WIDTH:  prdata = APB_DATA_BITS'(win_w_q);
      REG_WINDOW_HEIGHT: prdata = APB_DATA_BITS'(win_h_q);
      default:           prdata = '0;
    endcase
  end

  // Input register.
  logic                         s1_valid_q;
  logic                         s1_kind_q;
  logic signed [COORD_BITS-1:0] s1_sx_q, s1_sy_q, s1_ex_q, s1_ey_q;
  logic [23:0]                  s1_col_q;

  // Line state.
  phase_e                  phase_q, phase_d;
  logic [COORD_BITS-1:0]   cur_x_q, cur_x_d, cur_y_q, cur_y_d;
  logic [ERR_BITS-1:0]     err_q, err_d;
  logic [COORD_BITS-1:0]   major_q, major_d, minor_q, minor_d;
  logic [COORD_BITS-1:0]   steps_q, steps_d;
  logic                    x_neg_q, x_neg_d, y_neg_q, y_neg_d;
  logic                    x_major_q, x_major_d;
  logic [COORD_BITS-1:0]   sav_sx_q, sav_sx_d, sav_sy_q, sav_sy_d;
  logic [COORD_BITS-1:0]   sav_ex_q, sav_ex_d, sav_ey_q, sav_ey_d;
  logic [23:0]             col_q, col_d;

  // Output register.
  logic                  out_valid_q;
  logic [COORD_BITS-1:0] px_q, px_d, py_q, py_d;
  logic [23:0]           ocol_q;
  logic                  on_q, on_d, last_q, last_d;

  // Handshake between the two registers.
  logic s1_produces, out_free, s1_adv, in_acc;

  assign s1_produces = s1_valid_q && (s1_kind_q == KIND_STEP) && (phase_q != PH_IDLE);
  assign out_free    = !out_valid_q || out_ready_i;
  assign s1_adv      = s1_valid_q && (!s1_produces || out_free);
  assign in_ready_o  = !s1_valid_q || s1_adv;
  assign in_acc      = in_valid_i && in_ready_o;

  // Load datapath: absolute deltas and step directions.
  logic signed [DIFF_BITS-1:0] dx_s, dy_s;
  logic [COORD_BITS-1:0]       dx_abs, dy_abs;
  logic                        ld_x_major;

  assign dx_s   = DIFF_BITS'(s1_ex_q) - DIFF_BITS'(s1_sx_q);
  assign dy_s   = DIFF_BITS'(s1_ey_q) - DIFF_BITS'(s1_sy_q);
  assign dx_abs = dx_s[DIFF_BITS-1] ? COORD_BITS'(-dx_s) : dx_s[COORD_BITS-1:0];
  assign dy_abs = dy_s[DIFF_BITS-1] ? COORD_BITS'(-dy_s) : dy_s[COORD_BITS-1:0];
  assign ld_x_major = dx_abs > dy_abs;

  // Loop datapath: one error update and one position step.
  logic [ERR_BITS-1:0]   err_sum;
  logic                  move_minor;
  logic [COORD_BITS-1:0] x_next, y_next, loop_x, loop_y;

  assign err_sum    = err_q + ERR_BITS'(minor_q);
  assign move_minor = err_sum > ERR_BITS'(major_q);
  assign x_next     = x_neg_q ? cur_x_q - CB_ONE : cur_x_q + CB_ONE;
  assign y_next     = y_neg_q ? cur_y_q - CB_ONE : cur_y_q + CB_ONE;
  assign loop_x     = (x_major_q || move_minor) ? x_next : cur_x_q;
  assign loop_y     = (!x_major_q || move_minor) ? y_next : cur_y_q;

  // Next line state and pixel selection.
  always_comb begin
    phase_d   = phase_q;
    cur_x_d   = cur_x_q;
    cur_y_d   = cur_y_q;
    err_d     = err_q;
    major_d   = major_q;
    minor_d   = minor_q;
    steps_d   = steps_q;
    x_neg_d   = x_neg_q;
    y_neg_d   = y_neg_q;
    x_major_d = x_major_q;
    sav_sx_d  = sav_sx_q;
    sav_sy_d  = sav_sy_q;
    sav_ex_d  = sav_ex_q;
    sav_ey_d  = sav_ey_q;
    col_d     = col_q;
    px_d      = sav_ex_q;
    py_d      = sav_ey_q;
    last_d    = 1'b0;
    if (s1_adv) begin
      if (s1_kind_q == KIND_LOAD) begin
        sav_sx_d  = s1_sx_q;
        sav_sy_d  = s1_sy_q;
        sav_ex_d  = s1_ex_q;
        sav_ey_d  = s1_ey_q;
        col_d     = s1_col_q;
        x_neg_d   = !(s1_sx_q < s1_ex_q);
        y_neg_d   = !(s1_sy_q < s1_ey_q);
        x_major_d = ld_x_major;
        major_d   = ld_x_major ? dx_abs : dy_abs;
        minor_d   = ld_x_major ? dy_abs : dx_abs;
        err_d     = ERR_BITS'(major_d >> 1);
        steps_d   = major_d;
        cur_x_d   = s1_sx_q;
        cur_y_d   = s1_sy_q;
        phase_d   = (major_d != '0) ? PH_LOOP : PH_START;
      end else begin
        unique case (phase_q)
          PH_LOOP: begin
            err_d   = move_minor ? err_sum - ERR_BITS'(major_q) : err_sum;
            cur_x_d = loop_x;
            cur_y_d = loop_y;
            px_d    = loop_x;
            py_d    = loop_y;
            steps_d = steps_q - CB_ONE;
            if (steps_d == '0) begin
              phase_d = PH_START;
            end
          end
          PH_START: begin
            px_d    = sav_sx_q;
            py_d    = sav_sy_q;
            phase_d = PH_END;
          end
          PH_END: begin
            px_d    = sav_ex_q;
            py_d    = sav_ey_q;
            last_d  = 1'b1;
            phase_d = PH_IDLE;
          end
          PH_IDLE: ;
          default: ;
        endcase
      end
    end
  end

  // Clipping against the window.
  assign on_d = !px_d[COORD_BITS-1] && !py_d[COORD_BITS-1] &&
                (CMP_BITS'(px_d) < CMP_BITS'(win_w_q)) &&
                (CMP_BITS'(py_d) < CMP_BITS'(win_h_q));

  // Input register control and payload.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_acc) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_kind_q <= kind_i;
      s1_sx_q   <= start_x_i;
      s1_sy_q   <= start_y_i;
      s1_ex_q   <= end_x_i;
      s1_ey_q   <= end_y_i;
      s1_col_q  <= {red_in_i, green_in_i, blue_in_i};
    end
  end

  // Line state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_IDLE;
      cur_x_q   <= '0;
      cur_y_q   <= '0;
      err_q     <= '0;
      major_q   <= '0;
      minor_q   <= '0;
      steps_q   <= '0;
      x_neg_q   <= 1'b0;
      y_neg_q   <= 1'b0;
      x_major_q <= 1'b0;
      sav_sx_q  <= '0;
      sav_sy_q  <= '0;
      sav_ex_q  <= '0;
      sav_ey_q  <= '0;
      col_q     <= '0;
    end else begin
      phase_q   <= phase_d;
      cur_x_q   <= cur_x_d;
      cur_y_q   <= cur_y_d;
      err_q     <= err_d;
      major_q   <= major_d;
      minor_q   <= minor_d;
      steps_q   <= steps_d;
      x_neg_q   <= x_neg_d;
      y_neg_q   <= y_neg_d;
      x_major_q <= x_major_d;
      sav_sx_q  <= sav_sx_d;
      sav_sy_q  <= sav_sy_d;
      sav_ex_q  <= sav_ex_d;
      sav_ey_q  <= sav_ey_d;
      col_q     <= col_d;
    end
  end

  // Output register control and payload.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv && s1_produces) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_produces) begin
      px_q   <= px_d;
      py_q   <= py_d;
      ocol_q <= col_q;
      on_q   <= on_d;
      last_q <= last_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign pixel_x_o   = $signed(px_q);
  assign pixel_y_o   = $signed(py_q);
  assign red_out_o   = ocol_q[23:16];
  assign green_out_o = ocol_q[15:8];
  assign blue_out_o  = ocol_q[7:0];
  assign on_screen_o = on_q;
  assign last_o      = last_q;

  // The loop phase always has pixels left to emit.
  a_loop_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_LOOP |-> steps_q != '0)
    else $error("loop phase with no steps left");

  // The error accumulator never exceeds the major delta while looping.
  a_err_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_LOOP |-> err_q <= ERR_BITS'(major_q))
    else $error("error accumulator above major delta");

  // The end point step presents a last pixel and returns the line to idle.
  a_end_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv && s1_kind_q == KIND_STEP && phase_q == PH_END
    |=> out_valid_q && last_q && phase_q == PH_IDLE)
    else $error("end point not delivered as last pixel");

  // A pending pixel-producing beat is never dropped while the output is stalled.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_produces && out_valid_q && !out_ready_i |-> !in_ready_o && !s1_adv)
    else $error("input register advanced into a stalled output");

endmodule
